FILE: rtl/nvp_pkg.sv
package nvp_pkg;

    typedef enum logic [9:0] {
        PH_NL0   = 10'b00_0000_0001,
        PH_NL1   = 10'b00_0000_0010,
        PH_NL2   = 10'b00_0000_0100,
        PH_NL3   = 10'b00_0000_1000,
        PH_VL0   = 10'b00_0001_0000,
        PH_VL1   = 10'b00_0010_0000,
        PH_VL2   = 10'b00_0100_0000,
        PH_VL3   = 10'b00_1000_0000,
        PH_NAME  = 10'b01_0000_0000,
        PH_VALUE = 10'b10_0000_0000
    } t_phase;

    typedef logic [3:0] t_event;

    localparam t_event EV_LEN        = 4'd0;
    localparam t_event EV_NAME       = 4'd1;
    localparam t_event EV_VALUE      = 4'd2;
    localparam t_event EV_NAME_LONG  = 4'd3;
    localparam t_event EV_VALUE_LONG = 4'd4;
    localparam t_event EV_IGNORED    = 4'd5;
    localparam t_event EV_END_OK     = 4'd6;
    localparam t_event EV_TRUNC      = 4'd7;
    localparam t_event EV_END_ERR    = 4'd8;

    localparam logic [7:0] LONG_LEN_FLAG = 8'h80;
    localparam logic [7:0] LONG_LEN_MASK = 8'h1f;

    // Lengths keep their low 16 bits; any set bit above them is folded into a flag.
    typedef struct packed {
        t_phase      phase;
        logic        name_hi_nz;
        logic [15:0] name_len;
        logic        value_hi_nz;
        logic [15:0] value_len;
        logic [15:0] field_count;
        logic        error_seen;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:       PH_NL0,
        name_hi_nz:  1'b0,
        name_len:    16'd0,
        value_hi_nz: 1'b0,
        value_len:   16'd0,
        field_count: 16'd0,
        error_seen:  1'b0
    };

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  byte_out;
        logic [15:0] offset;
        logic [7:0]  name_length;
        logic [15:0] value_length;
        logic        pair_done;
    } t_result;

endpackage

FILE: rtl/nvp_decode.sv
module nvp_decode #(
    parameter int NAME_MAX = 128
) (
    input  nvp_pkg::t_state  i_state,
    input  logic             i_operation,
    input  logic [7:0]       i_data_byte,
    output nvp_pkg::t_state  o_state,
    output nvp_pkg::t_result o_result
);

    localparam logic [15:0] NAME_LIMIT = 16'(NAME_MAX);

    nvp_pkg::t_state n_st;
    nvp_pkg::t_event ev;
    logic [15:0]     off;
    logic [15:0]     count_inc;
    logic            done;
    logic            long_len;
    logic            low_bits_nz;
    logic            value_hi;

    assign count_inc   = i_state.field_count + 16'd1;
    assign long_len    = (i_data_byte & nvp_pkg::LONG_LEN_FLAG) != 8'd0;
    assign low_bits_nz = (i_data_byte & nvp_pkg::LONG_LEN_MASK) != 8'd0;
    assign value_hi    = i_state.value_hi_nz || (i_data_byte != 8'd0);

    always_comb begin
        n_st = i_state;
        ev   = nvp_pkg::EV_LEN;
        off  = 16'd0;
        done = 1'b0;
        if (i_operation) begin
            if (i_state.error_seen) begin
                ev = nvp_pkg::EV_END_ERR;
            end else if (i_state.phase != nvp_pkg::PH_NL0) begin
                ev = nvp_pkg::EV_TRUNC;
            end else begin
                ev = nvp_pkg::EV_END_OK;
            end
            n_st = nvp_pkg::STATE_RESET;
        end else if (i_state.error_seen) begin
            ev = nvp_pkg::EV_IGNORED;
        end else begin
            unique case (i_state.phase)
                nvp_pkg::PH_NL1: begin
                    n_st.name_hi_nz = i_state.name_hi_nz || (i_data_byte != 8'd0);
                    n_st.phase      = nvp_pkg::PH_NL2;
                end
                nvp_pkg::PH_NL2: begin
                    n_st.name_len = i_state.name_len | {i_data_byte, 8'd0};
                    n_st.phase    = nvp_pkg::PH_NL3;
                end
                nvp_pkg::PH_NL3: begin
                    n_st.name_len = i_state.name_len | {8'd0, i_data_byte};
                    if (i_state.name_hi_nz || (n_st.name_len > NAME_LIMIT)) begin
                        ev              = nvp_pkg::EV_NAME_LONG;
                        n_st.error_seen = 1'b1;
                    end else begin
                        n_st.phase = nvp_pkg::PH_VL0;
                    end
                end
                nvp_pkg::PH_VL0: begin
                    if (long_len) begin
                        n_st.value_hi_nz = low_bits_nz;
                        n_st.value_len   = 16'd0;
                        n_st.phase       = nvp_pkg::PH_VL1;
                    end else begin
                        n_st.value_hi_nz = 1'b0;
                        n_st.value_len   = {8'd0, i_data_byte};
                        n_st.field_count = 16'd0;
                        if (i_state.name_len != 16'd0) begin
                            n_st.phase = nvp_pkg::PH_NAME;
                        end else if (n_st.value_len != 16'd0) begin
                            n_st.phase = nvp_pkg::PH_VALUE;
                        end else begin
                            n_st.phase = nvp_pkg::PH_NL0;
                            done       = 1'b1;
                        end
                    end
                end
                nvp_pkg::PH_VL1: begin
                    if (value_hi) begin
                        ev               = nvp_pkg::EV_VALUE_LONG;
                        n_st.value_hi_nz = 1'b1;
                        n_st.error_seen  = 1'b1;
                    end else begin
                        n_st.phase = nvp_pkg::PH_VL2;
                    end
                end
                nvp_pkg::PH_VL2: begin
                    n_st.value_len = i_state.value_len | {i_data_byte, 8'd0};
                    n_st.phase     = nvp_pkg::PH_VL3;
                end
                nvp_pkg::PH_VL3: begin
                    n_st.value_len   = i_state.value_len | {8'd0, i_data_byte};
                    n_st.field_count = 16'd0;
                    if (i_state.name_len != 16'd0) begin
                        n_st.phase = nvp_pkg::PH_NAME;
                    end else if (n_st.value_len != 16'd0) begin
                        n_st.phase = nvp_pkg::PH_VALUE;
                    end else begin
                        n_st.phase = nvp_pkg::PH_NL0;
                        done       = 1'b1;
                    end
                end
                nvp_pkg::PH_NAME: begin
                    ev               = nvp_pkg::EV_NAME;
                    off              = i_state.field_count;
                    n_st.field_count = count_inc;
                    if (count_inc == i_state.name_len) begin
                        n_st.field_count = 16'd0;
                        if (i_state.value_len == 16'd0) begin
                            n_st.phase = nvp_pkg::PH_NL0;
                            done       = 1'b1;
                        end else begin
                            n_st.phase = nvp_pkg::PH_VALUE;
                        end
                    end
                end
                nvp_pkg::PH_VALUE: begin
                    ev               = nvp_pkg::EV_VALUE;
                    off              = i_state.field_count;
                    n_st.field_count = count_inc;
                    if (count_inc == i_state.value_len) begin
                        n_st.field_count = 16'd0;
                        n_st.phase       = nvp_pkg::PH_NL0;
                        done             = 1'b1;
                    end
                end
                default: begin
                    n_st.field_count = 16'd0;
                    n_st.value_len   = 16'd0;
                    n_st.value_hi_nz = 1'b0;
                    if (long_len) begin
                        n_st.name_len   = 16'd0;
                        n_st.name_hi_nz = low_bits_nz;
                        n_st.phase      = nvp_pkg::PH_NL1;
                    end else begin
                        n_st.name_len   = {8'd0, i_data_byte};
                        n_st.name_hi_nz = 1'b0;
                        n_st.phase      = nvp_pkg::PH_VL0;
                        if (n_st.name_len > NAME_LIMIT) begin
                            ev              = nvp_pkg::EV_NAME_LONG;
                            n_st.error_seen = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_state = n_st;
        if (i_operation) begin
            o_result              = '0;
            o_result.event_res    = ev;
        end else begin
            o_result.event_res    = ev;
            o_result.byte_out     = i_data_byte;
            o_result.offset       = off;
            o_result.name_length  = n_st.name_len[7:0];
            o_result.value_length = n_st.value_len;
            o_result.pair_done    = done;
        end
    end

endmodule

FILE: rtl/name_value_pair_stream_parser_unit.sv
// Name-value pair stream parser.
// The input channel (i_in_valid / o_in_ready) carries one word per item: i_operation
// selects a stream byte in i_data_byte or the end-of-parameters marker.
// The output channel (o_out_valid / i_out_ready) returns exactly one result word per
// input word: an event code, the byte passed through, its offset in its field,
// the decoded name and value lengths and a pair-complete flag.
// Each word is decoded combinationally by the parse step logic and lands in the
// output register, so the result appears in the cycle after acceptance.
// A new word is accepted every cycle while the result register is empty or
// being drained in the same cycle, giving one word per cycle sustained.
// When the receiver stalls, the held result stays unchanged and o_in_ready drops
// until the result is taken; no word is lost or repeated.
// Synchronous reset clears the parse state to expect a name length and empties
// the output register. An end marker reports how the stream ended and then
// returns the parse state to its reset values.
module name_value_pair_stream_parser_unit #(
    parameter int NAME_MAX = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_event_res,
    output logic [7:0]  o_byte_out,
    output logic [15:0] o_offset,
    output logic [7:0]  o_name_length,
    output logic [15:0] o_value_length,
    output logic        o_pair_done
);

    nvp_pkg::t_state  r_state;
    nvp_pkg::t_state  n_state;
    nvp_pkg::t_result r_result;
    nvp_pkg::t_result n_result;
    logic             r_out_valid;
    logic             accept;

    nvp_decode #(
        .NAME_MAX(NAME_MAX)
    ) u_decode (
        .i_state     (r_state),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nvp_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_result.event_res;
    assign o_byte_out     = r_result.byte_out;
    assign o_offset       = r_result.offset;
    assign o_name_length  = r_result.name_length;
    assign o_value_length = r_result.value_length;
    assign o_pair_done    = r_result.pair_done;

endmodule

FILE: tb/sv/nvp_result_checker.sv
`timescale 1ns / 100ps

module nvp_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_event_res,
    input  logic [7:0]  i_byte_out,
    input  logic [15:0] i_offset,
    input  logic [7:0]  i_name_length,
    input  logic [15:0] i_value_length,
    input  logic        i_pair_done,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NAME_LIMIT = 128;

    nvp_pkg::t_phase  phase_q;
    logic [28:0]      name_acc;
    logic [28:0]      value_acc;
    logic [15:0]      field_cnt;
    logic             err_flag;
    nvp_pkg::t_result expected_results[$];

    function automatic void clear_parse();
        phase_q   = nvp_pkg::PH_NL0;
        name_acc  = '0;
        value_acc = '0;
        field_cnt = '0;
        err_flag  = 1'b0;
    endfunction

    // Both lengths are known: pick the field that follows, or close an empty pair.
    function automatic logic lengths_done();
        field_cnt = '0;
        if (name_acc != 0) begin
            phase_q = nvp_pkg::PH_NAME;
            return 1'b0;
        end
        if (value_acc != 0) begin
            phase_q = nvp_pkg::PH_VALUE;
            return 1'b0;
        end
        phase_q = nvp_pkg::PH_NL0;
        return 1'b1;
    endfunction

    function automatic nvp_pkg::t_result decode_word(input logic op, input logic [7:0] b);
        nvp_pkg::t_result r;
        logic [28:0]      bx;
        r           = '0;
        r.event_res = nvp_pkg::EV_LEN;
        r.byte_out  = b;
        bx          = {21'd0, b};
        if (op) begin
            if (err_flag) begin
                r.event_res = nvp_pkg::EV_END_ERR;
            end else if (phase_q != nvp_pkg::PH_NL0) begin
                r.event_res = nvp_pkg::EV_TRUNC;
            end else begin
                r.event_res = nvp_pkg::EV_END_OK;
            end
            r.byte_out = '0;
            clear_parse();
            return r;
        end
        if (err_flag) begin
            r.event_res = nvp_pkg::EV_IGNORED;
        end else begin
            case (phase_q)
                nvp_pkg::PH_NL1: begin
                    name_acc |= bx << 16;
                    phase_q = nvp_pkg::PH_NL2;
                end
                nvp_pkg::PH_NL2: begin
                    name_acc |= bx << 8;
                    phase_q = nvp_pkg::PH_NL3;
                end
                nvp_pkg::PH_NL3: begin
                    name_acc |= bx;
                    if (name_acc > NAME_LIMIT) begin
                        r.event_res = nvp_pkg::EV_NAME_LONG;
                        err_flag = 1'b1;
                    end else begin
                        phase_q = nvp_pkg::PH_VL0;
                    end
                end
                nvp_pkg::PH_VL0: begin
                    if ((b & nvp_pkg::LONG_LEN_FLAG) != 0) begin
                        value_acc = 29'(b & nvp_pkg::LONG_LEN_MASK) << 24;
                        phase_q = nvp_pkg::PH_VL1;
                    end else begin
                        value_acc = bx;
                        r.pair_done = lengths_done();
                    end
                end
                nvp_pkg::PH_VL1: begin
                    value_acc |= bx << 16;
                    if (value_acc != 0) begin
                        r.event_res = nvp_pkg::EV_VALUE_LONG;
                        err_flag = 1'b1;
                    end else begin
                        phase_q = nvp_pkg::PH_VL2;
                    end
                end
                nvp_pkg::PH_VL2: begin
                    value_acc |= bx << 8;
                    phase_q = nvp_pkg::PH_VL3;
                end
                nvp_pkg::PH_VL3: begin
                    value_acc |= bx;
                    r.pair_done = lengths_done();
                end
                nvp_pkg::PH_NAME: begin
                    r.event_res = nvp_pkg::EV_NAME;
                    r.offset = field_cnt;
                    field_cnt = field_cnt + 16'd1;
                    if (field_cnt == name_acc) begin
                        field_cnt = '0;
                        if (value_acc == 0) begin
                            phase_q = nvp_pkg::PH_NL0;
                            r.pair_done = 1'b1;
                        end else begin
                            phase_q = nvp_pkg::PH_VALUE;
                        end
                    end
                end
                nvp_pkg::PH_VALUE: begin
                    r.event_res = nvp_pkg::EV_VALUE;
                    r.offset = field_cnt;
                    field_cnt = field_cnt + 16'd1;
                    if (field_cnt == value_acc) begin
                        field_cnt = '0;
                        phase_q = nvp_pkg::PH_NL0;
                        r.pair_done = 1'b1;
                    end
                end
                default: begin
                    field_cnt = '0;
                    value_acc = '0;
                    if ((b & nvp_pkg::LONG_LEN_FLAG) != 0) begin
                        name_acc = 29'(b & nvp_pkg::LONG_LEN_MASK) << 24;
                        phase_q = nvp_pkg::PH_NL1;
                    end else begin
                        name_acc = bx;
                        if (name_acc > NAME_LIMIT) begin
                            r.event_res = nvp_pkg::EV_NAME_LONG;
                            err_flag = 1'b1;
                        end
                        phase_q = nvp_pkg::PH_VL0;
                    end
                end
            endcase
        end
        r.name_length  = name_acc[7:0];
        r.value_length = value_acc[15:0];
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        nvp_pkg::t_result want;
        if (!i_rst_n) begin
            clear_parse();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word arrived with no expected result pending");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_res", want.event_res, i_event_res);
                    check_field("byte_out", want.byte_out, i_byte_out);
                    check_field("offset", want.offset, i_offset);
                    check_field("name_length", want.name_length, i_name_length);
                    check_field("value_length", want.value_length, i_value_length);
                    check_field("pair_done", want.pair_done, i_pair_done);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(decode_word(i_operation, i_data_byte));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: tb/sv/tb_name_value_pair_stream_parser_unit.sv
`timescale 1ns / 100ps

module tb_name_value_pair_stream_parser_unit;

    localparam int   WORD_TARGET  = 1550;
    localparam int   CYCLE_LIMIT  = 500000;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   HOLD_AT_WORD = 400;
    localparam int   DRAIN_CYCLES = 8;
    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_END       = 1'b1;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_operation = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_event_res;
    logic [7:0]  o_byte_out;
    logic [15:0] o_offset;
    logic [7:0]  o_name_length;
    logic [15:0] o_value_length;
    logic        o_pair_done;

    int fail_count;
    int pending;
    int words_sent = 0;
    int cycle_count = 0;
    bit tx_no_gaps = 1'b0;
    bit rx_no_gaps = 1'b0;

    name_value_pair_stream_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_byte_out     (o_byte_out),
        .o_offset       (o_offset),
        .o_name_length  (o_name_length),
        .o_value_length (o_value_length),
        .o_pair_done    (o_pair_done)
    );

    nvp_result_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_data_byte    (i_data_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_event_res    (o_event_res),
        .i_byte_out     (o_byte_out),
        .i_offset       (o_offset),
        .i_name_length  (o_name_length),
        .i_value_length (o_value_length),
        .i_pair_done    (o_pair_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_word(input logic op, input logic [7:0] b, input bit counted);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            tx_no_gaps = !tx_no_gaps;
        end
        gap = tx_no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (counted) begin
            words_sent++;
        end
    endtask

    task automatic send_length(input int unsigned len, input bit wide);
        if (wide || len > 127) begin
            send_word(OP_BYTE,
                      nvp_pkg::LONG_LEN_FLAG
                          | {1'b0, 2'($urandom_range(0, 3)), 5'(len >> 24)},
                      1'b1);
            send_word(OP_BYTE, 8'(len >> 16), 1'b1);
            send_word(OP_BYTE, 8'(len >> 8), 1'b1);
            send_word(OP_BYTE, 8'(len), 1'b1);
        end else begin
            send_word(OP_BYTE, 8'(len), 1'b1);
        end
    endtask

    task automatic send_field(input int unsigned count);
        repeat (count) send_word(OP_BYTE, 8'($urandom), 1'b1);
    endtask

    task automatic send_pair(input int unsigned name_len, input int unsigned value_len,
                             input bit wide_name, input bit wide_value);
        send_length(name_len, wide_name);
        send_length(value_len, wide_value);
        send_field(name_len);
        send_field(value_len);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int stall;
        int taken;
        taken = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 63) == 0) begin
                rx_no_gaps = !rx_no_gaps;
            end
            stall = rx_no_gaps ? 0 : $urandom_range(0, 11);
            if (taken == HOLD_AT_WORD) begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    initial begin
        int unsigned name_len;
        int unsigned value_len;
        int unsigned kind;
        int unsigned n;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_END, 8'hff, 1'b1);
        send_pair(1, 1, 1'b0, 1'b0);
        send_pair(0, 0, 1'b0, 1'b0);
        send_pair(2, 0, 1'b0, 1'b0);
        send_pair(0, 1, 1'b0, 1'b1);
        send_length(32'h1fff_ffff, 1'b1);
        send_word(OP_END, 8'h00, 1'b1);
        send_length(1, 1'b0);
        send_word(OP_BYTE, 8'h81, 1'b1);
        send_word(OP_BYTE, 8'h00, 1'b1);
        send_word(OP_BYTE, 8'h5a, 1'b0);
        send_word(OP_END, 8'h00, 1'b1);
        send_length(3, 1'b0);
        send_word(OP_END, 8'h7f, 1'b1);

        while (words_sent < WORD_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                case ($urandom_range(0, 19))
                    0:       name_len = 128;
                    1:       name_len = $urandom_range(0, 128);
                    default: name_len = $urandom_range(0, 6);
                endcase
                case ($urandom_range(0, 49))
                    0:       value_len = $urandom_range(300, 700);
                    1, 2, 3: value_len = $urandom_range(9, 60);
                    default: value_len = $urandom_range(0, 8);
                endcase
                send_pair(name_len, value_len, $urandom_range(0, 3) == 0,
                          $urandom_range(0, 3) == 0);
            end else if (kind < 78) begin
                send_word(OP_END, 8'($urandom), 1'b1);
            end else if (kind < 84) begin
                name_len  = $urandom_range(1, 5);
                value_len = $urandom_range(1, 5);
                case ($urandom_range(0, 3))
                    0: send_word(OP_BYTE, nvp_pkg::LONG_LEN_FLAG, 1'b1);
                    1: send_length(name_len, 1'($urandom_range(0, 1)));
                    2: begin
                        send_length(name_len, 1'b0);
                        send_length(value_len, 1'b1);
                        send_field($urandom_range(0, name_len - 1));
                    end
                    default: begin
                        send_length(name_len, 1'b0);
                        send_length(value_len, 1'b0);
                        send_field(name_len);
                        send_field($urandom_range(0, value_len - 1));
                    end
                endcase
                send_word(OP_END, 8'($urandom), 1'b1);
            end else if (kind < 90) begin
                if ($urandom_range(0, 1) == 1) begin
                    name_len = ($urandom_range(0, 1) == 1) ? 129
                                                           : $urandom_range(129, 32'h1fff_ffff);
                    send_length(name_len, 1'b1);
                end else begin
                    send_length($urandom_range(0, 4), 1'b0);
                    n = $urandom_range(0, 31);
                    send_word(OP_BYTE, nvp_pkg::LONG_LEN_FLAG | 8'(n), 1'b1);
                    send_word(OP_BYTE, 8'((n == 0) ? $urandom_range(1, 255)
                                                   : $urandom_range(0, 255)), 1'b1);
                end
                repeat ($urandom_range(0, 4)) send_word(OP_BYTE, 8'($urandom), 1'b0);
                send_word(OP_END, 8'($urandom), 1'b1);
            end else if (kind < 95) begin
                name_len  = $urandom_range(0, 3);
                value_len = ($urandom_range(0, 2) == 0) ? 16'hffff : $urandom_range(0, 16'hffff);
                send_length(name_len, 1'b0);
                send_length(value_len, 1'b1);
                send_field(name_len);
                n = $urandom_range(0, 5);
                send_field((value_len < n) ? value_len : n);
                send_word(OP_END, 8'($urandom), 1'b1);
            end else begin
                send_word(OP_END, 8'($urandom), 1'b1);
                send_field($urandom_range(1, 8));
                send_word(OP_END, 8'($urandom), 1'b1);
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
